/* rtl/aire_pkg.sv */
// Shared types and constants of the array insert/remove engine.
// Used by aire_cell and array_insert_remove_engine; depends on nothing.
package aire_pkg;

  localparam int unsigned FuncW    = 2;
  localparam int unsigned PosW     = 7;
  localparam int unsigned ValW     = 32;
  localparam int unsigned StatW    = 2;
  localparam int unsigned TotalW   = 7;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [FuncW-1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_READ   = 2'd3
  } func_e;

  typedef enum logic [StatW-1:0] {
    STAT_DONE     = 2'd0,
    STAT_REJECTED = 2'd1,
    STAT_NOMATCH  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_APPEND = 2'd1,
    CELL_INSERT = 2'd2,
    CELL_SHIFT  = 2'd3
  } cell_op_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_REMOVE = 1'b1
  } state_e;

endpackage

/* rtl/aire_cell.sv */
// One storage cell of the list: holds one entry and trades it with its neighbors.
// Depends on aire_pkg for the cell operation codes and the value width.
module aire_cell #(
  parameter int unsigned IW = 6,
  parameter int unsigned CW = 7
) (
  input  logic                      clk_i,
  input  aire_pkg::cell_op_e        op_i,
  input  logic [IW-1:0]             idx_i,
  input  logic [IW-1:0]             sel_i,
  input  logic [CW-1:0]             lim_i,
  input  logic [aire_pkg::ValW-1:0] wr_value_i,
  input  logic [aire_pkg::ValW-1:0] key_i,
  input  logic [aire_pkg::ValW-1:0] left_i,
  input  logic [aire_pkg::ValW-1:0] right_i,
  output logic [aire_pkg::ValW-1:0] data_o,
  output logic                      match_o
);

  logic [aire_pkg::ValW-1:0] data_q;
  logic [aire_pkg::ValW-1:0] data_d;

  always_comb begin
    data_d = data_q;
    unique case (op_i)
      aire_pkg::CELL_HOLD: begin
        data_d = data_q;
      end
      aire_pkg::CELL_APPEND: begin
        if (idx_i == sel_i) begin
          data_d = wr_value_i;
        end
      end
      aire_pkg::CELL_INSERT: begin
        if (idx_i == sel_i) begin
          data_d = wr_value_i;
        end else if ((idx_i > sel_i) && (CW'(idx_i) <= lim_i)) begin
          data_d = left_i;
        end
      end
      aire_pkg::CELL_SHIFT: begin
        if (idx_i >= sel_i) begin
          data_d = right_i;
        end
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = (data_q == key_i);

endmodule

/* rtl/array_insert_remove_engine.sv */
// Top level of the array insert/remove engine: control, count and result register.
// Depends on aire_pkg and on a row of aire_cell instances that hold the entries.
//
//   channel   direction  tdata (low bit up)               tuser
//   s_axis    in         position[6:0], operand[38:7]     func
//   m_axis    out        entry_total[6:0], read_data[38:7] status
//
// Append, insert and read finish in the cycle the request is accepted.
// Remove scans the entries from the first to the last held, then loads its result once the output is free;
// the cells shift left by one entry in each cycle that finds a match.
// Reset clears the count, the control state and the output valid; entries are unknown.
// A new request is taken while a result waits, as long as that result leaves this cycle.
module array_insert_remove_engine #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [aire_pkg::InDataW-1:0]  s_axis_tdata,  // position, operand_value
  input  logic [aire_pkg::FuncW-1:0]    s_axis_tuser,  // func
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [aire_pkg::OutDataW-1:0] m_axis_tdata,  // entry_total, read_data
  output logic [aire_pkg::StatW-1:0]    m_axis_tuser   // status
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > aire_pkg::PosW) ? CW : aire_pkg::PosW;

  aire_pkg::state_e          state_q, state_d;
  logic [CW-1:0]             count_q, count_d;
  logic [CW-1:0]             cursor_q, cursor_d;
  logic                      removed_q, removed_d;
  logic [aire_pkg::ValW-1:0] key_q;

  logic                        m_valid_q;
  logic [aire_pkg::StatW-1:0]  m_status_q;
  logic [aire_pkg::TotalW-1:0] m_total_q;
  logic [aire_pkg::ValW-1:0]   m_rdata_q;

  logic [aire_pkg::ValW-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]       cell_match;
  aire_pkg::cell_op_e        cell_op;
  logic [IW-1:0]             cell_sel;

  aire_pkg::func_e           in_func;
  logic [aire_pkg::PosW-1:0] in_pos;
  logic [aire_pkg::ValW-1:0] in_value;
  logic [XW-1:0]             pos_x;
  logic [XW-1:0]             count_x;
  logic                      out_free;
  logic                      accept;
  logic                      load_res;
  aire_pkg::status_e         res_status;
  logic [aire_pkg::ValW-1:0] res_rdata;

  assign in_func  = aire_pkg::func_e'(s_axis_tuser);
  assign in_pos   = s_axis_tdata[aire_pkg::PosW-1:0];
  assign in_value = s_axis_tdata[aire_pkg::PosW +: aire_pkg::ValW];
  assign pos_x    = XW'(in_pos);
  assign count_x  = XW'(count_q);

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == aire_pkg::ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    cursor_d   = cursor_q;
    removed_d  = removed_q;
    cell_op    = aire_pkg::CELL_HOLD;
    cell_sel   = '0;
    load_res   = 1'b0;
    res_status = aire_pkg::STAT_DONE;
    res_rdata  = '0;
    unique case (state_q)
      aire_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_func)
            aire_pkg::FUNC_APPEND: begin
              load_res = 1'b1;
              if (count_q < CW'(CAPACITY)) begin
                cell_op  = aire_pkg::CELL_APPEND;
                cell_sel = count_q[IW-1:0];
                count_d  = count_q + CW'(1);
              end else begin
                res_status = aire_pkg::STAT_REJECTED;
              end
            end
            aire_pkg::FUNC_INSERT: begin
              load_res = 1'b1;
              if ((pos_x != '0) && (pos_x <= count_x) && (count_q < CW'(CAPACITY))) begin
                cell_op  = aire_pkg::CELL_INSERT;
                cell_sel = IW'(pos_x - XW'(1));
                count_d  = count_q + CW'(1);
              end else begin
                res_status = aire_pkg::STAT_REJECTED;
              end
            end
            aire_pkg::FUNC_REMOVE: begin
              cursor_d  = '0;
              removed_d = 1'b0;
              state_d   = aire_pkg::ST_REMOVE;
            end
            aire_pkg::FUNC_READ: begin
              load_res = 1'b1;
              if (pos_x < count_x) begin
                res_rdata = cell_data[IW'(in_pos)];
              end else begin
                res_status = aire_pkg::STAT_REJECTED;
              end
            end
            default: begin
              load_res = 1'b0;
            end
          endcase
        end
      end
      aire_pkg::ST_REMOVE: begin
        if (cursor_q < count_q) begin
          if (cell_match[cursor_q[IW-1:0]]) begin
            cell_op   = aire_pkg::CELL_SHIFT;
            cell_sel  = cursor_q[IW-1:0];
            count_d   = count_q - CW'(1);
            removed_d = 1'b1;
          end else begin
            cursor_d = cursor_q + CW'(1);
          end
        end else if (out_free) begin
          load_res   = 1'b1;
          res_status = removed_q ? aire_pkg::STAT_DONE : aire_pkg::STAT_NOMATCH;
          state_d    = aire_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = aire_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= aire_pkg::ST_IDLE;
      count_q   <= '0;
      cursor_q  <= '0;
      removed_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      cursor_q  <= cursor_d;
      removed_q <= removed_d;
      if (load_res) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= in_value;
    end
    if (load_res) begin
      m_status_q <= res_status;
      m_total_q  <= aire_pkg::TotalW'(count_d);
      m_rdata_q  <= res_rdata;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [aire_pkg::ValW-1:0] left_data;
    logic [aire_pkg::ValW-1:0] right_data;

    if (g == 0) begin : g_first
      assign left_data = cell_data[g];
    end else begin : g_inner_left
      assign left_data = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_data = cell_data[g];
    end else begin : g_inner_right
      assign right_data = cell_data[g+1];
    end

    aire_cell #(
      .IW(IW),
      .CW(CW)
    ) u_cell (
      .clk_i     (clk_i),
      .op_i      (cell_op),
      .idx_i     (IW'(g)),
      .sel_i     (cell_sel),
      .lim_i     (count_q),
      .wr_value_i(in_value),
      .key_i     (key_q),
      .left_i    (left_data),
      .right_i   (right_data),
      .data_o    (cell_data[g]),
      .match_o   (cell_match[g])
    );
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {1'b0, m_rdata_q, m_total_q};

endmodule

/* test/tb_top.sv */
// Self-checking testbench for array_insert_remove_engine: a random and directed request
// stream is driven in bursts, and every result is compared against a behavioral list model.
// Depends on aire_pkg and the engine RTL only.
module tb_top;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned RANDOM_REQUESTS = 527;
  localparam int unsigned DRAIN_CYCLES = 2 * CAPACITY + 30;

  typedef struct {
    aire_pkg::func_e                func;
    logic [aire_pkg::PosW-1:0]      position;
    logic [aire_pkg::ValW-1:0]      operand;
  } list_request_t;

  typedef struct {
    aire_pkg::status_e              status;
    logic [aire_pkg::TotalW-1:0]    total;
    logic [aire_pkg::ValW-1:0]      data;
  } list_result_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  // position[6:0], operand_value[38:7], zero pad
  logic [aire_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic [aire_pkg::FuncW-1:0]    s_axis_tuser = '0;  // func
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  // entry_total[6:0], read_data[38:7], zero pad
  logic [aire_pkg::OutDataW-1:0] m_axis_tdata;
  logic [aire_pkg::StatW-1:0]    m_axis_tuser;       // status

  array_insert_remove_engine #(.CAPACITY(CAPACITY)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  list_request_t queued_requests[$];
  list_result_t  pending_results[$];
  logic [aire_pkg::ValW-1:0] shadow_list[CAPACITY];
  int unsigned     shadow_len;
  int unsigned     error_count = 0;

  list_request_t offered_req;
  int unsigned   burst_left;
  int unsigned   gap_left;
  logic          next_valid;

  int unsigned   ready_mode;
  int unsigned   mode_left;
  int unsigned   hold_left;
  int unsigned   results_seen;
  logic          hold_done;

  logic [aire_pkg::ValW-1:0] value_pool[8];

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic list_result_t model_list_op(list_request_t req);
    list_result_t res;
    int unsigned  i;
    int unsigned  kept;
    res.status = aire_pkg::STAT_DONE;
    res.data   = '0;
    case (req.func)
      aire_pkg::FUNC_APPEND: begin
        if (shadow_len >= CAPACITY) begin
          res.status = aire_pkg::STAT_REJECTED;
        end else begin
          shadow_list[shadow_len] = req.operand;
          shadow_len++;
        end
      end
      aire_pkg::FUNC_INSERT: begin
        if (req.position == 0 || req.position > shadow_len || shadow_len >= CAPACITY) begin
          res.status = aire_pkg::STAT_REJECTED;
        end else begin
          for (i = shadow_len; i > req.position - 1; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[req.position-1] = req.operand;
          shadow_len++;
        end
      end
      aire_pkg::FUNC_REMOVE: begin
        kept = 0;
        for (i = 0; i < shadow_len; i++) begin
          if (shadow_list[i] != req.operand) begin
            shadow_list[kept] = shadow_list[i];
            kept++;
          end
        end
        if (kept == shadow_len) res.status = aire_pkg::STAT_NOMATCH;
        else shadow_len = kept;
      end
      default: begin
        if (req.position < shadow_len) res.data = shadow_list[req.position];
        else res.status = aire_pkg::STAT_REJECTED;
      end
    endcase
    res.total = shadow_len[aire_pkg::TotalW-1:0];
    return res;
  endfunction

  // Sender: requests go out in bursts, most of them separated by idle gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      shadow_len = 0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) pending_results.push_back(model_list_op(offered_req));
      if (!s_axis_tvalid || s_axis_tready) begin
        next_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (queued_requests.size() > 0) begin
          offered_req = queued_requests.pop_front();
          s_axis_tdata <= {1'b0, offered_req.operand, offered_req.position};
          s_axis_tuser <= offered_req.func;
          next_valid = 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
        s_axis_tvalid <= next_valid;
      end
    end
  end

  // Receiver: switches between stall patterns and holds off once for a long stretch.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      ready_mode = 0;
      mode_left = 0;
      hold_left = 0;
      results_seen = 0;
      hold_done = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) results_seen++;
      if (mode_left == 0) begin
        ready_mode = $urandom_range(3);
        mode_left = $urandom_range(16, 80);
      end else begin
        mode_left--;
      end
      if (results_seen == 150 && !hold_done) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (ready_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(3) != 0);
          2: m_axis_tready <= ($urandom_range(3) == 0);
          default: m_axis_tready <= ~m_axis_tready;
        endcase
      end
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result with no request pending, status %0d total %0d data %h",
                 $time, m_axis_tuser, m_axis_tdata[6:0], m_axis_tdata[38:7]);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status) begin
          error_count++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, m_axis_tuser);
        end
        if (m_axis_tdata[6:0] !== want.total) begin
          error_count++;
          $display("%0t: entry_total expected %0d actual %0d",
                   $time, want.total, m_axis_tdata[6:0]);
        end
        if (m_axis_tdata[38:7] !== want.data) begin
          error_count++;
          $display("%0t: read_data expected %h actual %h", $time, want.data, m_axis_tdata[38:7]);
        end
      end
    end
  end

  task automatic push_request(aire_pkg::func_e func, int unsigned position,
                              logic [aire_pkg::ValW-1:0] operand);
    list_request_t req;
    req.func = func;
    req.position = position[aire_pkg::PosW-1:0];
    req.operand = operand;
    queued_requests.push_back(req);
  endtask

  function automatic logic [aire_pkg::ValW-1:0] pick_value();
    if ($urandom_range(9) < 6) return value_pool[$urandom_range(7)];
    return $urandom();
  endfunction

  initial begin
    int unsigned n;
    int unsigned len;
    int unsigned r;
    int unsigned pos;
    logic        growing;
    logic [aire_pkg::ValW-1:0] val;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (n = 4; n < 8; n++) value_pool[n] = $urandom();
    growing = 1'b1;
    wait (rst_ni);

    push_request(aire_pkg::FUNC_READ, 0, 32'h1234_5678);
    push_request(aire_pkg::FUNC_INSERT, 1, 32'd5);
    push_request(aire_pkg::FUNC_REMOVE, 64, 32'd7);
    push_request(aire_pkg::FUNC_APPEND, 0, 32'h8000_0000);
    push_request(aire_pkg::FUNC_APPEND, 127 & 64, 32'h7fff_ffff);
    push_request(aire_pkg::FUNC_APPEND, 0, 32'h0000_0000);
    push_request(aire_pkg::FUNC_APPEND, 0, 32'hffff_ffff);
    push_request(aire_pkg::FUNC_INSERT, 0, 32'd9);
    push_request(aire_pkg::FUNC_INSERT, 1, 32'd9);
    push_request(aire_pkg::FUNC_INSERT, 5, 32'd9);
    push_request(aire_pkg::FUNC_INSERT, 7, 32'd11);
    push_request(aire_pkg::FUNC_INSERT, 64, 32'd11);
    push_request(aire_pkg::FUNC_READ, 0, 32'd0);
    push_request(aire_pkg::FUNC_READ, 5, 32'hffff_ffff);
    push_request(aire_pkg::FUNC_READ, 6, 32'd0);
    push_request(aire_pkg::FUNC_READ, 64, 32'd0);
    push_request(aire_pkg::FUNC_REMOVE, 0, 32'd9);
    push_request(aire_pkg::FUNC_REMOVE, 0, 32'd123);
    push_request(aire_pkg::FUNC_REMOVE, 0, 32'h8000_0000);
    push_request(aire_pkg::FUNC_REMOVE, 0, 32'h7fff_ffff);
    push_request(aire_pkg::FUNC_REMOVE, 0, 32'h0000_0000);
    push_request(aire_pkg::FUNC_REMOVE, 0, 32'hffff_ffff);
    push_request(aire_pkg::FUNC_READ, 0, 32'd0);

    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      while (queued_requests.size() >= 4) @(negedge clk_i);
      if (n == 330) begin
        while (queued_requests.size() > 0 || s_axis_tvalid || pending_results.size() > 0)
          @(negedge clk_i);
      end
      len = shadow_len;
      if (growing && len >= CAPACITY) growing = 1'b0;
      else if (!growing && len < 4) growing = 1'b1;
      r = $urandom_range(99);
      if (r < 5) begin
        push_request(aire_pkg::func_e'($urandom_range(3)), $urandom_range(64), pick_value());
      end else if (r < (growing ? 40 : 25)) begin
        push_request(aire_pkg::FUNC_APPEND, $urandom_range(64), pick_value());
      end else if (r < (growing ? 70 : 40)) begin
        if ($urandom_range(9) == 0 || len == 0) pos = $urandom_range(64);
        else pos = $urandom_range(1, len);
        push_request(aire_pkg::FUNC_INSERT, pos, pick_value());
      end else if (r < (growing ? 85 : 70)) begin
        if ($urandom_range(9) == 0 || len == 0) pos = $urandom_range(64);
        else pos = $urandom_range(len - 1);
        push_request(aire_pkg::FUNC_READ, pos, $urandom());
      end else begin
        if (len > 0 && $urandom_range(9) < (growing ? 3 : 7))
          val = shadow_list[$urandom_range(len - 1)];
        else
          val = growing ? $urandom() : pick_value();
        push_request(aire_pkg::FUNC_REMOVE, $urandom_range(64), val);
      end
    end

    while (queued_requests.size() > 0 || s_axis_tvalid || pending_results.size() > 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
